// ----- sv/assert_macros.svh -----
// Assertion macros used by the port-level checker afr_checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/afr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the API frame receiver: widths, protocol byte codes,
// phase and kind codes, and the result struct. Depends on nothing.
package afr_pkg;

  localparam int BYTE_W = 8;
  localparam int PLEN_W = 16;
  localparam int FLEN_W = 17;
  localparam int KIND_W = 3;

  localparam logic [BYTE_W-1:0] START_DELIM  = 8'h7E;
  localparam logic [BYTE_W-1:0] TYPE_TX_STAT = 8'h8B;
  localparam logic [BYTE_W-1:0] TYPE_AT_RESP = 8'h88;

  localparam logic [FLEN_W-1:0] POS_TYPE  = 17'd3;
  localparam logic [FLEN_W-1:0] POS_SEVEN = 17'd7;
  localparam logic [FLEN_W-1:0] POS_EIGHT = 17'd8;
  localparam logic [FLEN_W-1:0] HDR_BYTES = 17'd4;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_BODY   = 4'b1000
  } afr_phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TX_OK   = 3'd0,
    KIND_TX_FAIL = 3'd1,
    KIND_AT_OK   = 3'd2,
    KIND_AT_ERR  = 3'd3,
    KIND_OTHER   = 3'd4
  } afr_kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] frame_kind;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] status_value;
    logic [FLEN_W-1:0] frame_length;
  } afr_result_t;

endpackage

// ----- sv/afr_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the API frame receiver: one received byte per item.
// Depends on afr_pkg.
interface afr_in_if;
  import afr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/afr_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the API frame receiver: one item per completed frame.
// Depends on afr_pkg.
interface afr_out_if;
  import afr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] frame_kind;
  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] status_value;
  logic [FLEN_W-1:0] frame_length;

  modport source (output valid, output frame_kind, output frame_type,
                  output status_value, output frame_length, input ready);
  modport sink   (input valid, input frame_kind, input frame_type,
                  input status_value, input frame_length, output ready);
endinterface

// ----- sv/api_frame_receiver_core.sv -----
`timescale 1ns / 1ps
// API frame receiver, top level.
// Channel rx carries one received serial byte per item; channel res carries
// one item per completed frame: its kind, type byte, byte eight and length.
// Bytes are skipped until a 0x7E delimiter; then a big-endian length L, L
// data bytes and a checksum follow, and the result appears after the
// checksum byte. The checksum is not checked.
// A byte accepted on rx is held in an input register and parsed from there
// once the parse step advances; a result it completes is written to the
// result register for res. One byte is taken every cycle while res is not
// stalled; the rate is set by the single parse step between the input
// register and the result register.
// When res stalls with a result waiting, the byte in the input register is
// held and rx drops ready only if that byte would need to advance; a byte
// that completes no frame still needs the parse step, so rx stalls too.
// Synchronous reset returns the parser to the delimiter hunt and empties
// both registers.
// Depends on afr_pkg, afr_in_if, afr_out_if and afr_parser.
module api_frame_receiver_core (
  input  logic      clk,
  input  logic      rst,
  afr_in_if.sink    rx,
  afr_out_if.source res
);
  import afr_pkg::*;

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              advance;
  logic              done;
  afr_result_t       result;
  logic              res_valid;
  afr_result_t       res_data;

  assign advance  = hold_valid && (!res_valid || res.ready);
  assign rx.ready = !hold_valid || advance;

  afr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (hold_byte),
    .done    (done),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      hold_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && done) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      res_data <= result;
    end
  end

  assign res.valid        = res_valid;
  assign res.frame_kind   = res_data.frame_kind;
  assign res.frame_type   = res_data.frame_type;
  assign res.status_value = res_data.status_value;
  assign res.frame_length = res_data.frame_length;

endmodule

// ----- sv/afr_parser.sv -----
`timescale 1ns / 1ps
// Frame parser state: delimiter hunt, length capture, body byte counting
// and classification of the finished frame. Depends on afr_pkg.
module afr_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [afr_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        done,
  output afr_pkg::afr_result_t        result
);
  import afr_pkg::*;

  afr_phase_t        phase, phase_next;
  logic [PLEN_W-1:0] payload_length, payload_length_next;
  logic [FLEN_W-1:0] byte_position, byte_position_next;
  logic [BYTE_W-1:0] captured_type, captured_type_next;
  logic [BYTE_W-1:0] captured_seven, captured_seven_next;
  logic [BYTE_W-1:0] captured_eight, captured_eight_next;
  logic [FLEN_W-1:0] last_position;

  assign last_position = {1'b0, payload_length} + POS_TYPE;

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_position_next  = byte_position;
    captured_type_next  = captured_type;
    captured_seven_next = captured_seven;
    captured_eight_next = captured_eight;
    done                = 1'b0;
    case (phase)
      PH_LEN_HI: begin
        payload_length_next = {rx_byte, payload_length[BYTE_W-1:0] & 8'h00};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = {payload_length[PLEN_W-1:BYTE_W], rx_byte};
        byte_position_next  = POS_TYPE;
        phase_next          = PH_BODY;
      end
      PH_BODY: begin
        if (byte_position == POS_TYPE) begin
          captured_type_next = rx_byte;
        end else if (byte_position == POS_SEVEN) begin
          captured_seven_next = rx_byte;
        end else if (byte_position == POS_EIGHT) begin
          captured_eight_next = rx_byte;
        end
        if (byte_position >= last_position) begin
          done               = 1'b1;
          phase_next         = PH_HUNT;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 17'd1;
        end
      end
      default: begin
        if (rx_byte == START_DELIM) begin
          phase_next          = PH_LEN_HI;
          captured_type_next  = '0;
          captured_seven_next = '0;
          captured_eight_next = '0;
          byte_position_next  = '0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    if (captured_type_next == TYPE_TX_STAT) begin
      result.frame_kind = (captured_eight_next == '0) ? KIND_TX_OK : KIND_TX_FAIL;
    end else if (captured_type_next == TYPE_AT_RESP) begin
      result.frame_kind = (captured_seven_next == '0) ? KIND_AT_OK : KIND_AT_ERR;
    end else begin
      result.frame_kind = KIND_OTHER;
    end
    result.frame_type   = captured_type_next;
    result.status_value = captured_eight_next;
    result.frame_length = {1'b0, payload_length} + HDR_BYTES;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      payload_length <= payload_length_next;
      captured_type  <= captured_type_next;
      captured_seven <= captured_seven_next;
      captured_eight <= captured_eight_next;
    end
  end

endmodule

// ----- sv/afr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the API frame receiver, bound to its top level.
// Depends on afr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [afr_pkg::KIND_W-1:0]  frame_kind,
  input logic [afr_pkg::BYTE_W-1:0]  frame_type,
  input logic [afr_pkg::BYTE_W-1:0]  status_value,
  input logic [afr_pkg::FLEN_W-1:0]  frame_length
);
  import afr_pkg::*;

  `AFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(frame_kind) && $stable(frame_type) && $stable(status_value) && $stable(frame_length), "stalled result item changed")
  `AFR_ASSERT_IMP(a_tx_kind, res_valid && (frame_kind == KIND_TX_OK || frame_kind == KIND_TX_FAIL), frame_type == TYPE_TX_STAT && ((frame_kind == KIND_TX_OK) == (status_value == '0)), "transmit status kind disagrees with type or status")
  `AFR_ASSERT_IMP(a_at_kind, res_valid && (frame_kind == KIND_AT_OK || frame_kind == KIND_AT_ERR), frame_type == TYPE_AT_RESP, "command response kind disagrees with type")
  `AFR_ASSERT_IMP(a_other_kind, res_valid, (frame_kind == KIND_OTHER) == (frame_type != TYPE_TX_STAT && frame_type != TYPE_AT_RESP), "other kind disagrees with type")
  `AFR_ASSERT_IMP(a_min_len, res_valid, frame_length >= HDR_BYTES, "frame length below header size")

endmodule

bind api_frame_receiver_core afr_checker u_afr_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .frame_kind   (res.frame_kind),
  .frame_type   (res.frame_type),
  .status_value (res.status_value),
  .frame_length (res.frame_length)
);

// ----- sim/afr_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the API frame receiver: watches both channels, tracks the frame
// parser state from the accepted bytes and compares every result item.
// Depends on afr_pkg, afr_in_if and afr_out_if.
module afr_frame_checker
  import afr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  afr_in_if    rx,
  afr_out_if   res,
  output int   fail_count,
  output int   pending,
  output int   frames_checked
);

  afr_phase_t        parse_phase;
  logic [PLEN_W-1:0] parse_len;
  logic [FLEN_W-1:0] parse_pos;
  logic [BYTE_W-1:0] seen_type;
  logic [BYTE_W-1:0] seen_seven;
  logic [BYTE_W-1:0] seen_eight;

  afr_result_t expected_frames[$];

  task automatic advance_parser(input logic [BYTE_W-1:0] b, output bit done,
                                output afr_result_t frame);
    logic [FLEN_W-1:0] last_pos;
    done = 1'b0;
    frame = '0;
    last_pos = {1'b0, parse_len} + POS_TYPE;
    case (parse_phase)
      PH_LEN_HI: begin
        parse_len = {b, 8'h00};
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        parse_len = {parse_len[15:8], b};
        parse_pos = POS_TYPE;
        parse_phase = PH_BODY;
      end
      PH_BODY: begin
        if (parse_pos == POS_TYPE) begin
          seen_type = b;
        end else if (parse_pos == POS_SEVEN) begin
          seen_seven = b;
        end else if (parse_pos == POS_EIGHT) begin
          seen_eight = b;
        end
        if (parse_pos >= last_pos) begin
          done = 1'b1;
          if (seen_type == TYPE_TX_STAT) begin
            frame.frame_kind = (seen_eight == 8'h00) ? KIND_TX_OK : KIND_TX_FAIL;
          end else if (seen_type == TYPE_AT_RESP) begin
            frame.frame_kind = (seen_seven == 8'h00) ? KIND_AT_OK : KIND_AT_ERR;
          end else begin
            frame.frame_kind = KIND_OTHER;
          end
          frame.frame_type = seen_type;
          frame.status_value = seen_eight;
          frame.frame_length = {1'b0, parse_len} + HDR_BYTES;
          parse_phase = PH_HUNT;
          parse_pos = '0;
        end else begin
          parse_pos = parse_pos + 17'd1;
        end
      end
      default: begin
        if (b == START_DELIM) begin
          parse_phase = PH_LEN_HI;
          seen_type = '0;
          seen_seven = '0;
          seen_eight = '0;
          parse_pos = '0;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    afr_result_t made;
    afr_result_t want;
    bit          done;
    if (rst) begin
      parse_phase = PH_HUNT;
      parse_len = '0;
      parse_pos = '0;
      seen_type = '0;
      seen_seven = '0;
      seen_eight = '0;
      expected_frames.delete();
      fail_count = 0;
      frames_checked = 0;
    end else begin
      if (rx.valid && rx.ready) begin
        advance_parser(rx.rx_byte, done, made);
        if (done) begin
          expected_frames.push_back(made);
        end
      end
      if (res.valid && res.ready) begin
        if (expected_frames.size() == 0) begin
          $error("result item with no frame expected: type %h length %0d",
                 res.frame_type, res.frame_length);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (res.frame_kind !== want.frame_kind) begin
            $error("frame_kind: expected %0d, got %0d", want.frame_kind, res.frame_kind);
            fail_count++;
          end
          if (res.frame_type !== want.frame_type) begin
            $error("frame_type: expected %h, got %h", want.frame_type, res.frame_type);
            fail_count++;
          end
          if (res.status_value !== want.status_value) begin
            $error("status_value: expected %h, got %h", want.status_value,
                   res.status_value);
            fail_count++;
          end
          if (res.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length,
                   res.frame_length);
            fail_count++;
          end
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

// ----- sim/tb_api_frame_receiver_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the API frame receiver: clock, reset, byte stream and
// result-side stalls, with the verdict. Depends on afr_pkg, the channel
// interfaces, api_frame_receiver_core and afr_frame_checker.
module tb_api_frame_receiver_core;
  import afr_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 200;
  localparam int STEADY_FIRST = 900;
  localparam int STEADY_LAST  = 1200;
  localparam int RANDOM_BYTES = 1320;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  afr_in_if  rx_ch ();
  afr_out_if res_ch ();

  int  fail_count;
  int  pending;
  int  frames_checked;
  int  quiet_cycles;
  bit  hold_request;
  bit  steady_window;
  logic [BYTE_W-1:0] rx_bytes[$];

  always #4 clk = ~clk;

  api_frame_receiver_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  afr_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx_ch),
    .res            (res_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  task automatic push_frame(input logic [BYTE_W-1:0] ftype, input logic [PLEN_W-1:0] plen,
                            input logic [BYTE_W-1:0] b7, input logic [BYTE_W-1:0] b8);
    int off;
    rx_bytes.push_back(START_DELIM);
    rx_bytes.push_back(plen[15:8]);
    rx_bytes.push_back(plen[7:0]);
    for (off = 3; off <= int'(plen) + 3; off++) begin
      rx_bytes.push_back(off == 3 ? ftype : off == 7 ? b7 : off == 8 ? b8 :
                         BYTE_W'($urandom));
    end
  endtask

  task automatic push_random_frame();
    int                pick;
    logic [BYTE_W-1:0] ftype;
    logic [PLEN_W-1:0] plen;
    pick = $urandom_range(99);
    ftype = pick < 40 ? TYPE_TX_STAT : pick < 80 ? TYPE_AT_RESP : BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      plen = PLEN_W'($urandom_range(3, 0));
    end else if (pick < 80) begin
      plen = PLEN_W'($urandom_range(16, 4));
    end else if (pick < 97) begin
      plen = PLEN_W'($urandom_range(40, 17));
    end else begin
      plen = PLEN_W'($urandom_range(276, 256));
    end
    push_frame(ftype, plen, $urandom_range(1) ? 8'h00 : BYTE_W'($urandom),
               $urandom_range(1) ? 8'h00 : BYTE_W'($urandom));
  endtask

  initial begin
    int n;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    hold_request <= 1'b0;
    steady_window <= 1'b0;

    // Junk before the first delimiter, then the frame shapes of interest.
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(8'h7D);
    push_frame(TYPE_TX_STAT, 16'd0, 8'h00, 8'h00);
    push_frame(TYPE_TX_STAT, 16'd7, 8'h00, 8'h03);
    push_frame(TYPE_AT_RESP, 16'd5, 8'h00, 8'hFF);
    push_frame(TYPE_AT_RESP, 16'd4, 8'h01, 8'h00);
    push_frame(START_DELIM, 16'd6, START_DELIM, START_DELIM);
    push_frame(TYPE_TX_STAT, 16'd7, START_DELIM, 8'h00);

    while (rx_bytes.size() < RANDOM_BYTES) begin
      if ($urandom_range(99) < 12) begin
        n = $urandom_range(4, 1);
        repeat (n) rx_bytes.push_back(8'(($urandom_range(99) < 50) ? 8'h00 :
                                          $urandom_range(8'h7D, 8'h00)));
      end else begin
        push_random_frame();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < rx_bytes.size(); i++) begin
      if (i == HOLD_AT) begin
        hold_request <= 1'b1;
      end
      steady_window <= (i >= STEADY_FIRST && i < STEADY_LAST);
      if (!(i >= STEADY_FIRST && i < STEADY_LAST) && $urandom_range(99) < 15) begin
        rx_ch.valid <= 1'b0;
        @(posedge clk);
      end
      rx_ch.valid <= 1'b1;
      rx_ch.rx_byte <= rx_bytes[i];
      @(posedge clk);
      while (!rx_ch.ready) @(posedge clk);
    end
    rx_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d received bytes and checked %0d completed frames of every kind,",
             rx_bytes.size(), frames_checked);
    $display("from zero-length frames to frames of over 256 bytes, with a %0d-cycle stall.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("[api_frame_receiver_core] OK");
    end else begin
      $display("[api_frame_receiver_core] ERROR");
    end
    $finish;
  end

  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_done) begin
        res_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        res_ch.ready <= steady_window || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles with no item accepted.", quiet_cycles);
      $display("[api_frame_receiver_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
